[rtl/sha_pkg.sv]
package sha_pkg;

  // round constants
  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  // initial hash values
  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] LEN_OFFSET = 7'd56;

  typedef logic [31:0] word_t;

  // request from sequencer to round engine
  typedef struct packed {
    logic start;
    logic init_hash;
  } eng_ctl_t;

  function automatic word_t ror(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/sha_round_engine.sv]
module sha_round_engine import sha_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  eng_ctl_t     ctl,
  input  logic [511:0] block,
  input  logic [2:0]   rd_index,
  output word_t        rd_word,
  output logic         busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_ADD = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [5:0]  rnd_r;
  word_t       w_r [16];
  word_t       v_r [8];
  word_t       h_r [8];
  word_t       w_cur, w_new, s0, s1, t1, t2, e, a;

  // schedule word for this round, next schedule word from the 16-word window
  always_comb begin
    w_cur = w_r[0];
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    e = v_r[4];
    a = v_r[0];
    t1 = v_r[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
         + round_k(rnd_r) + w_cur;
    t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (ctl.start) state_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 6'd63) state_nxt = S_ADD;
      S_ADD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ROUND) rnd_r <= rnd_r + 6'd1;
      else rnd_r <= '0;
    end
  end

  // hash state, working variables and schedule window
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init_hash) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else if (state_r == S_ADD) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
    if (state_r == S_IDLE && ctl.start) begin
      for (int i = 0; i < 16; i++) w_r[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  assign rd_word = h_r[rd_index];
  assign busy = (state_r != S_IDLE);

  a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == 6'd63) |=> state_r == S_ADD) else $error("round wrap");
  a_add_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |=> state_r == S_IDLE) else $error("add stage");
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> rnd_r == 6'd0) else $error("round count");

endmodule

[rtl/sha256_stream_hasher_unit.sv]
// channel | ports                                          | direction
// input   | in_valid in_ready in_data_byte in_byte_present in_final_item | in
// result  | out_valid out_ready out_digest_word out_word_index out_last_word | out
// byte items are taken back to back; the item with the 64th byte of a block is followed by
// engine start, load, 64 rounds, hash update and the return to input
// a final item: first digest word offered once any block it fills, then one padding
// block or two, are hashed; then 8 words, one a cycle while out_ready is high
// no item is taken while rounds run or the digest is being sent
// synchronous active-low reset restores the initial hash; out_ready stalls hold the word
module sha256_stream_hasher_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_final_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] S_IN = 3'd0;
  localparam logic [2:0] S_WAIT = 3'd1;
  localparam logic [2:0] S_PAD = 3'd2;
  localparam logic [2:0] S_PWAIT = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]   state_r;
  logic [511:0] blk_r;
  logic [511:0] pad_blk;
  logic [6:0]   fill_r;
  logic [60:0]  cnt_r;
  logic         fin_r;
  logic [2:0]   idx_r;
  logic         busy, acc, done;
  logic [63:0]  bits;
  eng_ctl_t     ctl_r, ctl_nxt;

  assign acc = in_valid && in_ready;
  assign in_ready = (state_r == S_IN);
  assign bits = {cnt_r, 3'b000};
  assign done = out_valid && out_ready && idx_r == 3'd7;

  // padded block: pad byte after the data, zeros behind it, length when it fits
  always_comb begin
    pad_blk = blk_r;
    for (int i = 0; i < 64; i++) begin
      if (7'(i) == fill_r) pad_blk[511 - 8*i -: 8] = PAD_BYTE;
      else if (7'(i) > fill_r) pad_blk[511 - 8*i -: 8] = 8'h00;
    end
    if (fill_r < LEN_OFFSET) pad_blk[63:0] = bits;
  end

  // engine start and hash reinit requests
  always_comb begin
    ctl_nxt = '0;
    case (state_r)
      S_IN:    ctl_nxt.start = acc && in_byte_present && fill_r == 7'd63;
      S_PAD:   ctl_nxt.start = 1'b1;
      S_PWAIT: ctl_nxt.start = !ctl_r.start && !busy && fill_r == 7'd127;
      S_OUT:   ctl_nxt.init_hash = out_ready && idx_r == 3'd7;
      default: ctl_nxt = '0;
    endcase
  end

  // sequencer state and byte lane writes: byte i sits at bits 511-8i
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      fill_r <= '0;
      cnt_r <= '0;
      fin_r <= 1'b0;
      idx_r <= '0;
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
      case (state_r)
        S_IN: if (acc) begin
          fin_r <= in_final_item;
          if (in_byte_present) begin
            blk_r[511 - 8*fill_r[5:0] -: 8] <= in_data_byte;
            cnt_r <= cnt_r + 61'd1;
            if (fill_r == 7'd63) begin
              fill_r <= '0;
              state_r <= S_WAIT;
            end else begin
              fill_r <= fill_r + 7'd1;
              if (in_final_item) state_r <= S_PAD;
            end
          end else if (in_final_item) state_r <= S_PAD;
        end
        // wait for block rounds; a pending final item goes on to padding
        S_WAIT: if (!ctl_r.start && !busy) state_r <= fin_r ? S_PAD : S_IN;
        // pad byte and zeros fill the rest of the block, with the length when it fits
        S_PAD: begin
          blk_r <= pad_blk;
          fill_r <= (fill_r < LEN_OFFSET) ? 7'd64 : 7'd127;
          state_r <= S_PWAIT;
        end
        // 127 marks a length-only block still to do
        S_PWAIT: if (!ctl_r.start && !busy) begin
          if (fill_r == 7'd127) begin
            blk_r <= {448'd0, bits};
            fill_r <= 7'd64;
          end else state_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          idx_r <= idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            fill_r <= '0;
            cnt_r <= '0;
            fin_r <= 1'b0;
            state_r <= S_IN;
          end
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  sha_round_engine u_eng (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_r), .block(blk_r),
    .rd_index(idx_r), .rd_word(out_digest_word), .busy(busy)
  );

  assign out_valid = (state_r == S_OUT);
  assign out_word_index = idx_r;
  assign out_last_word = (idx_r == 3'd7);

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("input taken during rounds");
  a_done_reset: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> cnt_r == 61'd0 && fill_r == 7'd0) else $error("no reset after digest");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("digest read during rounds");

endmodule
